// File: hw/rtl/utf8_to_utf16_stream_decoder_assert.svh
// Assertion macros for the UTF-8 to UTF-16 stream decoder.
// Both expect clk_i and rst_ni in the scope of use.
`ifndef UTF8_TO_UTF16_STREAM_DECODER_ASSERT_SVH
`define UTF8_TO_UTF16_STREAM_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only out of reset.
`define U8U16_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");
// Checked at every edge, reset included.
`define U8U16_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("%m: check failed");
`else
`define U8U16_ASSERT(name, prop)
`define U8U16_ASSERT_ALWAYS(name, prop)
`endif

`endif

// File: hw/rtl/u8u16_pkg.sv
package u8u16_pkg;

  typedef enum logic [2:0] {
    KIND_MARK       = 3'd0,
    KIND_CHAR       = 3'd1,
    KIND_BAD_LEAD   = 3'd2,
    KIND_BAD_SECOND = 3'd3,
    KIND_BAD_THIRD  = 3'd4
  } kind_e;

  // Configuration register indexes
  localparam logic CfgBigEndian = 1'b0;
  localparam logic CfgStripBom  = 1'b1;

  localparam int unsigned MaxResults = 3;
  localparam int unsigned QueueDepth = MaxResults + 1;

  localparam logic [15:0] MarkUnit = 16'hFEFF;
  localparam logic [7:0]  BomByte0 = 8'hEF;
  localparam logic [7:0]  BomByte1 = 8'hBB;
  localparam logic [7:0]  BomByte2 = 8'hBF;

  typedef struct packed {
    logic big_endian;
    logic strip_bom;
  } cfg_t;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    kind_e      kind;
    logic       last;
  } result_t;

  // Open multi-byte sequence
  typedef struct packed {
    logic [15:0] code;
    logic [1:0]  len;
    logic [1:0]  seen;
  } dec_t;

  typedef struct packed {
    dec_t        st;
    logic        valid;
    kind_e       kind;
    logic [15:0] unit;
  } dec_res_t;

  function automatic dec_res_t decode_byte(dec_t st, logic [7:0] b);
    dec_res_t    r;
    logic [15:0] code_ext;
    logic [1:0]  seen_inc;
    r        = '{st: st, valid: 1'b0, kind: KIND_CHAR, unit: 16'h0000};
    code_ext = {st.code[9:0], b[5:0]};
    seen_inc = st.seen + 2'd1;
    if (st.len == 2'd0) begin
      if (!b[7]) begin
        r.valid = 1'b1;
        r.unit  = {8'h00, b};
      end else if (b[7:5] == 3'b110) begin
        r.st = '{code: {11'd0, b[4:0]}, len: 2'd2, seen: 2'd1};
      end else if (b[7:4] == 4'b1110) begin
        r.st = '{code: {12'd0, b[3:0]}, len: 2'd3, seen: 2'd1};
      end else begin
        r.valid = 1'b1;
        r.kind  = KIND_BAD_LEAD;
      end
    end else if (b[7:6] == 2'b10) begin
      if (seen_inc >= st.len) begin
        r.valid = 1'b1;
        r.unit  = code_ext;
        r.st    = '0;
      end else begin
        r.st.code = code_ext;
        r.st.seen = seen_inc;
      end
    end else begin
      // abandon the open sequence and consume the byte
      r.valid = 1'b1;
      r.kind  = (st.seen <= 2'd1) ? KIND_BAD_SECOND : KIND_BAD_THIRD;
      r.st    = '0;
    end
    return r;
  endfunction

  function automatic result_t make_result(kind_e kind, logic [15:0] unit, logic big_endian);
    result_t r;
    r.kind = kind;
    r.last = 1'b0;
    if (kind == KIND_CHAR || kind == KIND_MARK) begin
      r.first  = big_endian ? unit[15:8] : unit[7:0];
      r.second = big_endian ? unit[7:0]  : unit[15:8];
    end else begin
      r.first  = 8'h00;
      r.second = 8'h00;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/u8u16_core.sv
`include "utf8_to_utf16_stream_decoder_assert.svh"

module u8u16_core (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  u8u16_pkg::cfg_t                                  cfg_i,
  input  logic                                             s_valid_i,
  output logic                                             s_ready_o,
  input  logic [7:0]                                       s_byte_i,
  input  logic                                             s_start_i,
  input  logic                                             space_ok_i,
  output logic [1:0]                                       push_n_o,
  output u8u16_pkg::result_t [u8u16_pkg::MaxResults-1:0]   push_o
);
  import u8u16_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;
  dec_t       dec_q, dec_d;
  logic       done_q, done_d;
  logic [1:0] held_count_q, held_count_d;
  logic [7:0] held0_q, held1_q;

  logic       adv;
  dec_t       st0, st1, st2;
  logic [1:0] hc;
  logic       done;
  logic       bom_match;
  logic       en0, en1, en2;
  dec_res_t   dr0, dr1, dr2;
  result_t    cand [4];
  logic [3:0] cand_v;
  result_t    res_all [4];
  logic [1:0] pos;

  assign adv       = in_valid_q && space_ok_i;
  assign s_ready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_ready_o) begin
      in_valid_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      in_byte_q  <= s_byte_i;
      in_start_q <= s_start_i;
    end
  end

  always_comb begin
    st0       = in_start_q ? '0 : dec_q;
    hc        = in_start_q ? 2'd0 : held_count_q;
    done      = in_start_q ? 1'b0 : done_q;
    bom_match = (held0_q == BomByte0) && (held1_q == BomByte1) && (in_byte_q == BomByte2);

    en0          = 1'b0;
    en1          = 1'b0;
    en2          = 1'b0;
    done_d       = 1'b1;
    held_count_d = 2'd0;
    if (done) begin
      en2 = 1'b1;
    end else if (cfg_i.strip_bom) begin
      if (hc == 2'd2) begin
        // third byte completes the check: replay unless it was a mark
        en0 = !bom_match;
        en1 = !bom_match;
        en2 = !bom_match;
      end else begin
        done_d       = 1'b0;
        held_count_d = hc + 2'd1;
      end
    end else begin
      en0 = (hc >= 2'd1);
      en1 = (hc >= 2'd2);
      en2 = 1'b1;
    end

    dr0   = decode_byte(st0, held0_q);
    st1   = en0 ? dr0.st : st0;
    dr1   = decode_byte(st1, held1_q);
    st2   = en1 ? dr1.st : st1;
    dr2   = decode_byte(st2, in_byte_q);
    dec_d = en2 ? dr2.st : st2;

    cand[0]   = make_result(KIND_MARK, MarkUnit, cfg_i.big_endian);
    cand[1]   = make_result(dr0.kind, dr0.unit, cfg_i.big_endian);
    cand[2]   = make_result(dr1.kind, dr1.unit, cfg_i.big_endian);
    cand[3]   = make_result(dr2.kind, dr2.unit, cfg_i.big_endian);
    cand_v[0] = in_start_q;
    cand_v[1] = en0 && dr0.valid;
    cand_v[2] = en1 && dr1.valid;
    cand_v[3] = en2 && dr2.valid;

    // pack the valid candidates to the front, in order
    pos = 2'd0;
    for (int i = 0; i < 4; i++) begin
      res_all[i] = cand[0];
    end
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i] && pos != 2'd3) begin
        res_all[pos] = cand[i];
        pos          = pos + 2'd1;
      end
    end
    if (pos != 2'd0) begin
      res_all[pos - 2'd1].last = 1'b1;
    end

    push_n_o = adv ? pos : 2'd0;
    for (int i = 0; i < MaxResults; i++) begin
      push_o[i] = res_all[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_q        <= '0;
      done_q       <= 1'b0;
      held_count_q <= 2'd0;
    end else if (adv) begin
      dec_q        <= dec_d;
      done_q       <= done_d;
      held_count_q <= held_count_d;
    end
  end

  // hold the first two bytes of a stream for the mark check
  always_ff @(posedge clk_i) begin
    if (adv && !done && cfg_i.strip_bom) begin
      if (hc == 2'd0) begin
        held0_q <= in_byte_q;
      end
      if (hc == 2'd1) begin
        held1_q <= in_byte_q;
      end
    end
  end

  `U8U16_ASSERT(holdNoOpenSeq_A, !done_q |-> (dec_q.len == 2'd0 && dec_q.seen == 2'd0))
  `U8U16_ASSERT(startGivesMark_A, (adv && in_start_q) |-> push_n_o != 2'd0)
  `U8U16_ASSERT(heldCountRange_A, held_count_q != 2'd3)

endmodule

// File: hw/rtl/u8u16_outq.sv
`include "utf8_to_utf16_stream_decoder_assert.svh"

module u8u16_outq (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic [1:0]                                       push_n_i,
  input  u8u16_pkg::result_t [u8u16_pkg::MaxResults-1:0]   push_i,
  output logic                                             space_ok_o,
  output logic                                             m_valid_o,
  input  logic                                             m_ready_i,
  output u8u16_pkg::result_t                               m_data_o
);
  import u8u16_pkg::*;

  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned IdxW = $clog2(QueueDepth);

  result_t         slot_q [QueueDepth];
  result_t         slot_d [QueueDepth];
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] cnt_after;
  logic            pop;
  logic [IdxW-1:0] src;
  logic [CntW-1:0] k;

  assign pop        = m_valid_o && m_ready_i;
  assign m_valid_o  = (count_q != '0);
  assign m_data_o   = slot_q[0];
  // room for the largest burst one byte can cause
  assign space_ok_o = (count_q <= CntW'(QueueDepth - MaxResults));

  always_comb begin
    cnt_after = count_q - CntW'(pop);
    count_d   = cnt_after + CntW'(push_n_i);
    src       = '0;
    k         = '0;
    for (int i = 0; i < QueueDepth; i++) begin
      src = IdxW'(i) + IdxW'(pop);
      k   = CntW'(i) - cnt_after;
      if (CntW'(i) < cnt_after) begin
        slot_d[i] = slot_q[src];
      end else if (k < CntW'(push_n_i)) begin
        slot_d[i] = push_i[k[1:0]];
      end else begin
        slot_d[i] = slot_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QueueDepth; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  `U8U16_ASSERT(pushNeedsRoom_A, (push_n_i != 2'd0) |-> space_ok_o)
  `U8U16_ASSERT(drainLast_A, (count_q == CntW'(1) && pop && push_n_i == 2'd0) |=> !m_valid_o)
  `U8U16_ASSERT(countRange_A, count_q <= CntW'(QueueDepth))

endmodule

// File: hw/rtl/utf8_to_utf16_stream_decoder.sv
// UTF-8 to UTF-16 stream decoder.
// Input channel s_axis: one UTF-8 byte per transfer; s_axis_tuser flags the
// first byte of a new stream, which clears the decoder and emits a
// byte-order mark ahead of anything else that byte causes.
// Output channel m_axis: one 16-bit code unit per transfer as two bytes in
// write order, the kind in tuser, and tlast on the last result of a byte.
// Error results carry zero bytes. A byte causes zero to three results.
// Config port: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 big_endian, 1 strip_input_bom); write only while the block is idle.
// A byte accepted on s_axis passes the input register and then the result
// queue before its first result can transfer on m_axis.
// Throughput: one byte per cycle while each byte gives at most one result and
// m_axis_tready is high; a byte with more results holds back the input while
// the single output port drains a four-entry result queue.
// When m_axis_tready is low the queue fills and s_axis_tready drops once
// more than one result waits; nothing is lost or repeated.
// Reset: decoder idle, no bytes held, queue empty, little endian output,
// mark stripping enabled.
`include "utf8_to_utf16_stream_decoder_assert.svh"

module utf8_to_utf16_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] stream_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] first_out_byte, [15:8] second_out_byte
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_wdata_i
);
  import u8u16_pkg::*;

  cfg_t                       cfg_q;
  logic                       space_ok;
  logic [1:0]                 push_n;
  result_t [MaxResults-1:0]   push;
  result_t                    out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{big_endian: 1'b0, strip_bom: 1'b1};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgBigEndian: cfg_q.big_endian <= cfg_wdata_i;
        CfgStripBom:  cfg_q.strip_bom  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  u8u16_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .s_byte_i   (s_axis_tdata),
    .s_start_i  (s_axis_tuser),
    .space_ok_i (space_ok),
    .push_n_o   (push_n),
    .push_o     (push)
  );

  u8u16_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_n_i   (push_n),
    .push_i     (push),
    .space_ok_o (space_ok),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (out_res)
  );

  assign m_axis_tdata = {out_res.second, out_res.first};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule
